### rtl/core/bsl_pkg.sv
// Shared types and constants for the button scan block with long-press repeat.
// Event kinds, the lane event record, the configuration record and reset values.
// Depends on nothing; every other file of the block imports it.
package bsl_pkg;

  // Fixed field widths
  localparam int LEVELS_W   = 4;
  localparam int BTN_W      = 2;
  localparam int CNT_W      = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Button count limits and default
  localparam int BUTTONS_DEF = 4;
  localparam int BUTTONS_MAX = 8;

  // Counter limit
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration reset values
  localparam int HOLD_TICKS_DEF = 10;
  localparam logic [CNT_W-1:0] LONG_THR_RST   = CNT_W'(HOLD_TICKS_DEF);
  localparam logic [CNT_W-1:0] REPEAT_RLD_RST = CNT_W'(HOLD_TICKS_DEF / 3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RELOAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PRESS   = 2'd2;

  // Event kinds as carried on tuser
  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_LONG    = 2'd1,
    KIND_PRESS   = 2'd2
  } kind_e;

  // One lane's finding for one scan tick
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } bsl_event_t;

  // Configuration seen by every lane
  typedef struct packed {
    logic [CNT_W-1:0] long_threshold;
    logic [CNT_W-1:0] repeat_reload;
    logic             report_press;
  } bsl_cfg_t;

endpackage

### rtl/core/button_scan_long_press_repeat.sv
// Button scan with release, press and long-press auto-repeat events, one lane per button.
// Path: an accepted tick passes the holding slot and then the current slot of bsl_merge before tvalid rises.
// Throughput: one tick per cycle while the result port keeps up; a tick with several events holds
// the result port until all have left, and input stalls while a held tick waits behind one still draining.
// Reset: all buttons released, hold counters zero, registers at defaults, no events pending.
// Depends on bsl_pkg, bsl_lane and bsl_merge.
module button_scan_long_press_repeat
  import bsl_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Scan tick input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [3:0] levels, rest ignored
  // Event output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] button, rest zero
  output logic [1:0]            m_axis_tuser,   // [1:0] kind
  output logic                  m_axis_tlast,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bsl_cfg_t                 cfg_q;
  bsl_event_t [BUTTONS-1:0] lane_ev;
  logic       [BUTTONS-1:0] lane_level;
  logic                     s_fire;

  assign cfg_ready_o = 1'b1;
  assign s_fire      = s_axis_tvalid & s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_threshold <= LONG_THR_RST;
      cfg_q.repeat_reload  <= REPEAT_RLD_RST;
      cfg_q.report_press   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LONG_THRESHOLD: cfg_q.long_threshold <= cfg_data_i;
        REG_REPEAT_RELOAD:  cfg_q.repeat_reload  <= cfg_data_i;
        REG_REPORT_PRESS:   cfg_q.report_press   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // One lane per button; buttons above the levels field read as pressed
  for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
    if (g < LEVELS_W) begin : g_in
      assign lane_level[g] = s_axis_tdata[g];
    end else begin : g_out
      assign lane_level[g] = 1'b0;
    end

    bsl_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (s_fire),
      .level_i (lane_level[g]),
      .cfg_i   (cfg_q),
      .ev_o    (lane_ev[g])
    );
  end

  // Serialize lane events in button order
  bsl_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s_fire),
    .ev_i          (lane_ev),
    .load_ready_o  (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/core/bsl_lane.sv
// One button lane: last level and hold counter, event decision per scan tick.
// Depends on bsl_pkg for the event and configuration records.
module bsl_lane
  import bsl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       level_i,
  input  bsl_cfg_t   cfg_i,
  output bsl_event_t ev_o
);

  logic             last_level_q, last_level_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  logic [CNT_W-1:0] hold_inc;

  // Saturating increment of the hold counter
  assign hold_inc = (hold_q == CNT_MAX) ? hold_q : hold_q + CNT_W'(1);

  // Decide this tick's event and next state
  always_comb begin
    last_level_d = last_level_q;
    hold_d       = hold_q;
    ev_o.valid   = 1'b0;
    ev_o.kind    = KIND_RELEASE;
    if ((level_i != last_level_q) && (hold_q == '0)) begin
      last_level_d = level_i;
      hold_d       = '0;
      if (level_i) begin
        ev_o.valid = 1'b1;
        ev_o.kind  = KIND_RELEASE;
      end else if (cfg_i.report_press) begin
        ev_o.valid = 1'b1;
        ev_o.kind  = KIND_PRESS;
      end
    end else if (!level_i) begin
      hold_d = hold_inc;
      if (hold_inc >= cfg_i.long_threshold) begin
        ev_o.valid = 1'b1;
        ev_o.kind  = KIND_LONG;
        hold_d     = cfg_i.repeat_reload;
      end
    end else begin
      hold_d = '0;
    end
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b1;
      hold_q       <= '0;
    end else if (step_i) begin
      last_level_q <= last_level_d;
      hold_q       <= hold_d;
    end
  end

endmodule

### rtl/core/bsl_merge.sv
// Merge stage: buffers the lane events of one tick and sends them out in button order.
// A holding slot takes the next tick while the current one still drains.
// Depends on bsl_pkg for the event record and field widths.
module bsl_merge
  import bsl_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  bsl_event_t [BUTTONS-1:0]   ev_i,
  output logic                       load_ready_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [1:0] button, rest zero
  output logic [1:0]                 m_axis_tuser,  // [1:0] kind
  output logic                       m_axis_tlast
);

  bsl_event_t [BUTTONS-1:0] hold_ev_q;
  logic                     hold_v_q, hold_v_d;
  bsl_event_t [BUTTONS-1:0] cur_ev_q, cur_ev_d;

  logic [BUTTONS-1:0] cur_mask, pick_oh, rest_mask;
  logic [BTN_W-1:0]   pick_idx;
  kind_e              pick_kind;
  logic               pick_found;
  logic               any_ev, m_fire, cur_free, move;

  // Gather valid bits of the incoming tick and of the current tick
  always_comb begin
    any_ev = 1'b0;
    for (int i = 0; i < BUTTONS; i++) begin
      any_ev      = any_ev | ev_i[i].valid;
      cur_mask[i] = cur_ev_q[i].valid;
    end
  end

  // Pick the lowest pending button
  always_comb begin
    pick_found = 1'b0;
    pick_oh    = '0;
    pick_idx   = '0;
    pick_kind  = KIND_RELEASE;
    for (int i = 0; i < BUTTONS; i++) begin
      if (cur_ev_q[i].valid && !pick_found) begin
        pick_found = 1'b1;
        pick_oh[i] = 1'b1;
        pick_idx   = BTN_W'(i);
        pick_kind  = cur_ev_q[i].kind;
      end
    end
  end

  assign rest_mask     = cur_mask & ~pick_oh;
  assign m_axis_tvalid = pick_found;
  assign m_axis_tdata  = OUT_DATA_W'(pick_idx);
  assign m_axis_tuser  = pick_kind;
  assign m_axis_tlast  = (rest_mask == '0);
  assign m_fire        = m_axis_tvalid & m_axis_tready;

  // Current slot frees when empty or when its final event leaves;
  // the holding slot takes a new tick in the same cycle that it hands one over
  assign cur_free     = (cur_mask == '0) || (m_fire && m_axis_tlast);
  assign move         = hold_v_q & cur_free;
  assign load_ready_o = !hold_v_q || cur_free;

  // Advance holding slot and current slot
  always_comb begin
    hold_v_d = hold_v_q;
    if (load_i) begin
      hold_v_d = any_ev;
    end else if (move) begin
      hold_v_d = 1'b0;
    end
    cur_ev_d = cur_ev_q;
    if (move) begin
      cur_ev_d = hold_ev_q;
    end else if (m_fire) begin
      for (int i = 0; i < BUTTONS; i++) begin
        cur_ev_d[i].valid = rest_mask[i];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        cur_ev_q[i].valid <= 1'b0;
        cur_ev_q[i].kind  <= KIND_RELEASE;
      end
    end else begin
      hold_v_q <= hold_v_d;
      cur_ev_q <= cur_ev_d;
    end
  end

  // Payload of the holding slot
  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      hold_ev_q <= ev_i;
    end
  end

  // Events of one tick leave back to back
  a_tick_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && !m_axis_tlast |=> m_axis_tvalid)
    else $error("events of one tick not contiguous");

  // At most one button picked
  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick_oh))
    else $error("more than one button picked");

  // Nothing pending means nothing offered next
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_mask == '0) && !hold_v_q |=> !m_axis_tvalid)
    else $error("result offered with nothing pending");

  // A drained tick with an empty holding slot leaves the output idle
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && m_axis_tlast && !hold_v_q |=> !m_axis_tvalid)
    else $error("result offered after final event with no tick held");

endmodule

### bench/button_scan_long_press_repeat_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the button scan block: scan ticks in, button events out.
// Predicts release, press and long-press repeat events per tick. Depends on bsl_pkg.
module button_scan_long_press_repeat_tb;
  import bsl_pkg::*;

  localparam int BUTTONS   = BUTTONS_DEF;
  localparam int STALL_LEN = 120;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    kind_e            kind;
    logic             last;
  } btn_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [3:0] levels, rest zero
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [1:0] button, rest zero
  logic [1:0]            m_axis_tuser;        // [1:0] kind
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predicted button state and register copies
  logic             btn_lvl  [BUTTONS];
  logic [CNT_W-1:0] btn_hold [BUTTONS];
  logic [CNT_W-1:0] long_thr;
  logic [CNT_W-1:0] reload_val;
  logic             press_en;

  logic [LEVELS_W-1:0] scan_ticks[$];
  btn_event_t          pending_events[$];
  btn_event_t          want;
  logic [LEVELS_W-1:0] last_lv = '1;
  int                  pushed_ticks = 0;
  int                  accepted_ticks = 0;
  int                  fail_cnt = 0;
  int                  in_gap = 0;
  int                  out_wait = 0;
  int                  stall_at = 32'h7fff_ffff;
  int                  stall_left = 0;
  logic                stall_done = 1'b0;
  logic                calm = 1'b0;

  button_scan_long_press_repeat #(
    .BUTTONS(BUTTONS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advance the button state by one tick and queue the events it causes
  function automatic void detect_events(input logic [LEVELS_W-1:0] lv);
    logic lvl;
    int   found;
    found = 0;
    for (int n = 0; n < BUTTONS; n++) begin
      lvl = lv[n];
      if (lvl != btn_lvl[n] && btn_hold[n] == '0) begin
        if (lvl) begin
          pending_events.push_back('{BTN_W'(n), KIND_RELEASE, 1'b0});
          found++;
        end else if (press_en) begin
          pending_events.push_back('{BTN_W'(n), KIND_PRESS, 1'b0});
          found++;
        end
        btn_lvl[n]  = lvl;
        btn_hold[n] = '0;
      end else if (!lvl) begin
        if (btn_hold[n] != CNT_MAX) btn_hold[n] = btn_hold[n] + 1'b1;
        if (btn_hold[n] >= long_thr) begin
          pending_events.push_back('{BTN_W'(n), KIND_LONG, 1'b0});
          found++;
          btn_hold[n] = reload_val;
        end
      end else begin
        btn_hold[n] = '0;
      end
    end
    // Mark the final event of this tick
    if (found > 0) pending_events[$].last = 1'b1;
  endfunction

  function automatic void push_tick(input logic [LEVELS_W-1:0] lv);
    scan_ticks.push_back(lv);
    pushed_ticks++;
    last_lv = lv;
  endfunction

  // Tick driver: hold each item until accepted, then idle for a drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      in_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        detect_events(s_axis_tdata[LEVELS_W-1:0]);
        accepted_ticks <= accepted_ticks + 1;
        in_gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (scan_ticks.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'(scan_ticks.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, triggered once by the tick count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && accepted_ticks >= stall_at) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Event monitor: compare each transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event: button %0d kind %0d", m_axis_tdata[BTN_W-1:0],
                 m_axis_tuser);
          fail_cnt++;
        end else begin
          want = pending_events.pop_front();
          if (m_axis_tdata[BTN_W-1:0] != want.button) begin
            $error("button: expected %0d, got %0d", want.button, m_axis_tdata[BTN_W-1:0]);
            fail_cnt++;
          end
          if (kind_e'(m_axis_tuser) != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tlast != want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_cnt++;
          end
        end
        out_wait = calm ? 0 : $urandom_range(0, 7);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (out_wait != 0) begin
        out_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Wait until every tick is taken and every event has come out
  task automatic settle();
    while (accepted_ticks != pushed_ticks || pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LONG_THRESHOLD: long_thr   = val;
      REG_REPEAT_RELOAD:  reload_val = val;
      REG_REPORT_PRESS:   press_en   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [CNT_W-1:0] thr, input logic [CNT_W-1:0] rld,
                          input logic rp, input logic quiet);
    settle();
    write_reg(REG_LONG_THRESHOLD, thr);
    write_reg(REG_REPEAT_RELOAD, rld);
    write_reg(REG_REPORT_PRESS, CFG_DATA_W'(rp));
    calm = quiet;
  endtask

  // Mostly held levels with occasional flips, plus some fully random ticks
  task automatic random_ticks(input int count, input int flip_div, input int noise_div);
    logic [LEVELS_W-1:0] lv;
    lv = last_lv;
    repeat (count) begin
      if ($urandom_range(0, noise_div - 1) == 0) begin
        lv = LEVELS_W'($urandom_range(0, (1 << LEVELS_W) - 1));
      end else begin
        for (int b = 0; b < LEVELS_W; b++)
          if ($urandom_range(0, flip_div - 1) == 0) lv[b] = ~lv[b];
      end
      push_tick(lv);
    end
  endtask

  initial begin
    for (int n = 0; n < BUTTONS; n++) begin
      btn_lvl[n]  = 1'b1;
      btn_hold[n] = '0;
    end
    long_thr   = LONG_THR_RST;
    reload_val = REPEAT_RLD_RST;
    press_en   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: presses, long-press repeats, late release, alternating buttons
    set_mode(8'd3, 8'd1, 1'b1, 1'b0);
    push_tick(4'hF);
    repeat (6) push_tick(4'h0);
    push_tick(4'hF);
    push_tick(4'hF);
    push_tick(4'hA);
    push_tick(4'h5);
    push_tick(4'hF);

    // Directed: threshold zero, reload zero, press events dropped
    set_mode(8'd0, 8'd0, 1'b0, 1'b0);
    repeat (3) push_tick(4'h0);
    push_tick(4'h9);
    push_tick(4'hF);
    push_tick(4'h6);

    // Random: back-to-back traffic with one long receiver hold-off
    set_mode(8'd4, 8'd2, 1'b1, 1'b1);
    stall_at = pushed_ticks + 4;
    random_ticks(70, 3, 10);

    // Random: reload above threshold
    set_mode(8'd5, 8'd7, 1'b0, 1'b0);
    random_ticks(60, 6, 10);

    // Random: threshold one, reload zero
    set_mode(8'd1, 8'd0, 1'b1, 1'b0);
    random_ticks(50, 4, 8);

    // Random: highest threshold, reload just below it, mostly noise
    set_mode(8'd255, 8'd254, 1'b0, 1'b0);
    random_ticks(40, 2, 3);

    // Random: default timing with long holds
    set_mode(LONG_THR_RST, REPEAT_RLD_RST, 1'b1, 1'b0);
    random_ticks(60, 12, 15);

    // Random: reload of 254, every held tick repeats
    set_mode(8'd2, 8'd254, 1'b1, 1'b0);
    random_ticks(30, 5, 10);

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bsl_pkg.sv
rtl/core/bsl_lane.sv
rtl/core/bsl_merge.sv
rtl/core/button_scan_long_press_repeat.sv
bench/button_scan_long_press_repeat_tb.sv
